// ===== design/glcm_pkg.sv =====
// Shared types and constants for the co-occurrence accumulator.
package glcm_pkg;

  localparam int GREY_BITS      = 8;
  localparam int OBJ_ID_BITS    = 3;
  localparam int OBJ_IDX_BITS   = 6;
  localparam int READ_OBJ_BITS  = 2;
  localparam int OP_BITS        = 2;
  localparam int SIZE_BITS      = 11;
  localparam int DIR_BITS       = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OP_BITS-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_ABOVE = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd2;

  typedef enum logic [1:0] {
    CMD_PAIR  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [OBJ_IDX_BITS-1:0]  obj;
    logic [GREY_BITS-1:0]     first;
    logic [GREY_BITS-1:0]     second;
    logic                     obj_ok;
    logic                     cell_ok;
  } cmd_t;

endpackage

// ===== design/glcm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module glcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/glcm_queue.sv =====
// Short command queue between the pixel front end and the count engine.
module glcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  glcm_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output glcm_pkg::cmd_t  pop_cmd
);
  import glcm_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != (PTR_BITS + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== design/glcm_front.sv =====
// Front end: takes items, tracks the raster position and line buffer, and emits commands.
module glcm_front #(
  parameter int MAX_OBJECTS = 4,
  parameter int GREY_LEVELS = 256,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [glcm_pkg::OP_BITS-1:0]         operation,
  input  logic [glcm_pkg::GREY_BITS-1:0]       grey,
  input  logic [glcm_pkg::OBJ_ID_BITS-1:0]     object,
  input  logic [glcm_pkg::READ_OBJ_BITS-1:0]   read_object,
  input  logic [glcm_pkg::GREY_BITS-1:0]       read_first,
  input  logic [glcm_pkg::GREY_BITS-1:0]       read_second,
  input  logic                                 cfg_write,
  input  logic [glcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [glcm_pkg::SIZE_BITS-1:0]       cfg_data,
  input  logic                                 init_done,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output glcm_pkg::cmd_t                       push_cmd
);
  import glcm_pkg::*;

  localparam int LEVEL_BITS = $clog2(GREY_LEVELS);
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int W_BITS     = ($clog2(MAX_WIDTH + 1) > SIZE_BITS) ?
                              $clog2(MAX_WIDTH + 1) : SIZE_BITS;
  localparam int H_BITS     = ($clog2(MAX_HEIGHT + 1) > SIZE_BITS) ?
                              $clog2(MAX_HEIGHT + 1) : SIZE_BITS;
  localparam int LINE_BITS  = OBJ_ID_BITS + LEVEL_BITS;
  localparam int CMP_BITS   = 8;

  logic [DIR_BITS-1:0]      direction;
  logic [SIZE_BITS-1:0]     image_width;
  logic [SIZE_BITS-1:0]     image_height;
  logic [COL_BITS-1:0]      column_position;
  logic [ROW_BITS-1:0]      row_position;
  logic [LEVEL_BITS-1:0]    previous_grey;
  logic [OBJ_ID_BITS-1:0]   previous_object;

  logic                     hold_valid;
  logic [OP_BITS-1:0]       hold_op;
  logic [GREY_BITS-1:0]     hold_grey;
  logic [OBJ_ID_BITS-1:0]   hold_object;
  logic [READ_OBJ_BITS-1:0] hold_read_object;
  logic [GREY_BITS-1:0]     hold_first;
  logic [GREY_BITS-1:0]     hold_second;

  logic [W_BITS-1:0]        w_eff;
  logic [H_BITS-1:0]        h_eff;
  logic [COL_BITS-1:0]      c_eff;
  logic [ROW_BITS-1:0]      r_eff;
  logic [W_BITS-1:0]        c_inc;
  logic [H_BITS-1:0]        r_inc;
  logic [COL_BITS-1:0]      column_next;
  logic [ROW_BITS-1:0]      row_next;

  logic [LEVEL_BITS-1:0]    g_sat;
  logic [OBJ_ID_BITS-1:0]   o_sat;
  logic [LINE_BITS-1:0]     line_rd;
  logic [LEVEL_BITS-1:0]    line_grey;
  logic [OBJ_ID_BITS-1:0]   line_object;

  logic                     pair_valid;
  logic [OBJ_ID_BITS-1:0]   pair_obj;
  logic [LEVEL_BITS-1:0]    pair_a;
  logic [LEVEL_BITS-1:0]    pair_b;
  logic                     is_pixel;
  logic                     need_cmd;
  logic                     commit;
  logic                     accept;

  always_comb begin
    if (image_width == '0) begin
      w_eff = W_BITS'(1);
    end else if (W_BITS'(image_width) > W_BITS'(MAX_WIDTH)) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = W_BITS'(image_width);
    end
    if (image_height == '0) begin
      h_eff = H_BITS'(1);
    end else if (H_BITS'(image_height) > H_BITS'(MAX_HEIGHT)) begin
      h_eff = H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = H_BITS'(image_height);
    end
  end

  assign c_eff = (W_BITS'(column_position) >= w_eff) ? '0 : column_position;
  assign r_eff = (H_BITS'(row_position) >= h_eff) ? '0 : row_position;
  assign c_inc = W_BITS'(c_eff) + W_BITS'(1);
  assign r_inc = H_BITS'(r_eff) + H_BITS'(1);

  always_comb begin
    column_next = c_inc[COL_BITS-1:0];
    row_next    = r_eff;
    if (c_inc >= w_eff) begin
      column_next = '0;
      row_next    = (r_inc >= h_eff) ? '0 : r_inc[ROW_BITS-1:0];
    end
  end

  assign g_sat = ((CMP_BITS + 1)'(hold_grey) >= (CMP_BITS + 1)'(GREY_LEVELS)) ?
                 LEVEL_BITS'(GREY_LEVELS - 1) : hold_grey[LEVEL_BITS-1:0];
  assign o_sat = ((CMP_BITS - 1)'(hold_object) > (CMP_BITS - 1)'(MAX_OBJECTS)) ?
                 '0 : hold_object;

  glcm_ram #(
    .WIDTH(LINE_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (commit && is_pixel),
    .wr_addr (c_eff),
    .wr_data ({o_sat, g_sat}),
    .rd_addr (c_eff),
    .rd_data (line_rd)
  );

  assign line_grey   = line_rd[LEVEL_BITS-1:0];
  assign line_object = line_rd[LINE_BITS-1:LEVEL_BITS];

  always_comb begin
    pair_valid = 1'b0;
    pair_obj   = '0;
    pair_a     = '0;
    pair_b     = '0;
    case (direction)
      DIR_RIGHT: begin
        pair_valid = (c_eff != '0) && (previous_object != '0);
        pair_obj   = previous_object;
        pair_a     = previous_grey;
        pair_b     = g_sat;
      end
      DIR_ABOVE: begin
        pair_valid = (r_eff != '0) && (o_sat != '0);
        pair_obj   = o_sat;
        pair_a     = g_sat;
        pair_b     = line_grey;
      end
      DIR_LEFT: begin
        pair_valid = (c_eff != '0) && (o_sat != '0);
        pair_obj   = o_sat;
        pair_a     = g_sat;
        pair_b     = previous_grey;
      end
      default: begin
        pair_valid = (r_eff != '0) && (line_object != '0);
        pair_obj   = line_object;
        pair_a     = line_grey;
        pair_b     = g_sat;
      end
    endcase
  end

  always_comb begin
    push_cmd.kind    = CMD_PAIR;
    push_cmd.obj     = OBJ_IDX_BITS'(pair_obj - OBJ_ID_BITS'(1));
    push_cmd.first   = GREY_BITS'(pair_a);
    push_cmd.second  = GREY_BITS'(pair_b);
    push_cmd.obj_ok  = 1'b1;
    push_cmd.cell_ok = 1'b1;
    if (hold_op == OP_READ) begin
      push_cmd.kind    = CMD_READ;
      push_cmd.obj     = OBJ_IDX_BITS'(hold_read_object);
      push_cmd.first   = hold_first;
      push_cmd.second  = hold_second;
      push_cmd.obj_ok  = (CMP_BITS'(hold_read_object) < CMP_BITS'(MAX_OBJECTS));
      push_cmd.cell_ok = ((CMP_BITS + 1)'(hold_first) < (CMP_BITS + 1)'(GREY_LEVELS)) &&
                         ((CMP_BITS + 1)'(hold_second) < (CMP_BITS + 1)'(GREY_LEVELS));
    end else if (hold_op == OP_CLEAR) begin
      push_cmd.kind = CMD_CLEAR;
    end
  end

  assign is_pixel   = (hold_op == OP_PIXEL);
  assign need_cmd   = (is_pixel && pair_valid) || (hold_op == OP_READ) ||
                      (hold_op == OP_CLEAR);
  assign push_valid = hold_valid && need_cmd;
  assign commit     = hold_valid && (!need_cmd || push_ready);
  assign in_ready   = !hold_valid && init_done;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid      <= 1'b0;
      direction       <= DIR_RIGHT;
      image_width     <= SIZE_RESET;
      image_height    <= SIZE_RESET;
      column_position <= '0;
      row_position    <= '0;
      previous_grey   <= '0;
      previous_object <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (commit) begin
        hold_valid <= 1'b0;
      end
      if (commit && is_pixel) begin
        previous_grey   <= g_sat;
        previous_object <= o_sat;
        column_position <= column_next;
        row_position    <= row_next;
      end
      if (cfg_write) begin
        if (cfg_index == REG_DIRECTION) begin
          direction <= cfg_data[DIR_BITS-1:0];
        end else if (cfg_index == REG_WIDTH) begin
          image_width     <= cfg_data;
          column_position <= '0;
          row_position    <= '0;
        end else if (cfg_index == REG_HEIGHT) begin
          image_height    <= cfg_data;
          column_position <= '0;
          row_position    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_op          <= operation;
      hold_grey        <= grey;
      hold_object      <= object;
      hold_read_object <= read_object;
      hold_first       <= read_first;
      hold_second      <= read_second;
    end
  end

endmodule

// ===== design/glcm_back.sv =====
// Count engine: read-modify-write of the count memory, totals, reads and clearing.
module glcm_back #(
  parameter int MAX_OBJECTS = 4,
  parameter int GREY_LEVELS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  glcm_pkg::cmd_t        cmd,
  output logic                  init_done,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] count,
  output logic [COUNT_BITS-1:0] pair_total
);
  import glcm_pkg::*;

  localparam int LEVEL_BITS = $clog2(GREY_LEVELS);
  localparam int OBJ_BITS   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int ADDR_BITS  = OBJ_BITS + 2 * LEVEL_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SECOND = 5'b00100,
    ST_THIRD  = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  state_t                state;
  state_t                state_next;
  cmd_t                  cur;
  logic [ADDR_BITS-1:0]  sweep;
  logic [COUNT_BITS-1:0] totals [MAX_OBJECTS];

  logic [OBJ_BITS-1:0]   cmd_k;
  logic [OBJ_BITS-1:0]   cur_k;
  logic [LEVEL_BITS-1:0] cur_a;
  logic [LEVEL_BITS-1:0] cur_b;
  logic [ADDR_BITS-1:0]  cmd_addr;
  logic [ADDR_BITS-1:0]  cur_addr1;
  logic [ADDR_BITS-1:0]  cur_addr2;
  logic                  same_cell;

  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  out_load;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                    input logic [1:0] inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + (COUNT_BITS + 1)'(inc);
    sat_add = s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  assign cmd_k     = cmd.obj[OBJ_BITS-1:0];
  assign cur_k     = cur.obj[OBJ_BITS-1:0];
  assign cur_a     = cur.first[LEVEL_BITS-1:0];
  assign cur_b     = cur.second[LEVEL_BITS-1:0];
  assign cmd_addr  = {cmd_k, cmd.first[LEVEL_BITS-1:0], cmd.second[LEVEL_BITS-1:0]};
  assign cur_addr1 = {cur_k, cur_a, cur_b};
  assign cur_addr2 = {cur_k, cur_b, cur_a};
  assign same_cell = (cur_a == cur_b);

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign out_load = (state == ST_RESULT) && (!out_valid || out_ready);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = cur_addr1;
    wr_data    = '0;
    rd_addr    = cur_addr1;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep;
        if (&sweep) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = cmd_addr;
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_PAIR:  state_next = ST_SECOND;
            CMD_READ:  state_next = ST_RESULT;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SECOND: begin
        wr_en      = 1'b1;
        wr_data    = sat_add(rd_data, same_cell ? 2'd2 : 2'd1);
        rd_addr    = cur_addr2;
        state_next = same_cell ? ST_IDLE : ST_THIRD;
      end
      ST_THIRD: begin
        wr_en      = 1'b1;
        wr_addr    = cur_addr2;
        wr_data    = sat_add(rd_data, 2'd1);
        rd_addr    = cur_addr2;
        state_next = ST_IDLE;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  glcm_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(2 ** ADDR_BITS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      init_done <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
        totals[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
        if (&sweep) begin
          init_done <= 1'b1;
        end
      end
      if (cmd_pop && (cmd.kind == CMD_CLEAR)) begin
        sweep <= '0;
        for (int i = 0; i < MAX_OBJECTS; i++) begin
          totals[i] <= '0;
        end
      end
      if (state == ST_SECOND) begin
        totals[cur_k] <= sat_add(totals[cur_k], 2'd2);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (out_load) begin
      count      <= (cur.obj_ok && cur.cell_ok) ? rd_data : '0;
      pair_total <= cur.obj_ok ? totals[cur_k] : '0;
    end
  end

endmodule

// ===== design/glcm_accumulator_unit.sv =====
// Top level of the grey level co-occurrence accumulator.
//
//   Channel   Signals                                          Handshake
//   input     operation grey object read_object read_first     in_valid / in_ready
//             read_second
//   result    count pair_total                                 out_valid / out_ready
//   config    cfg_index cfg_data                               cfg_write, no wait
//
// The front end takes an item, reads the line buffer, then classifies it and pushes a
// command into a four-entry queue before it takes the next. The count engine reads and
// writes both cells of a pixel pair (one cell when both grey levels are equal), looks
// up a read, and on a clear writes every count memory entry, 2**(log2 objects +
// 2*log2 levels), 262144 at the defaults; its single read and single write port set
// the pace. After reset the same pass runs before the first item is taken. A stalled
// result holds in the output register; the queue lets the front continue.
module glcm_accumulator_unit #(
  parameter int MAX_OBJECTS = 4,
  parameter int GREY_LEVELS = 256,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int COUNT_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [glcm_pkg::OP_BITS-1:0]         operation,
  input  logic [glcm_pkg::GREY_BITS-1:0]       grey,
  input  logic [glcm_pkg::OBJ_ID_BITS-1:0]     object,
  input  logic [glcm_pkg::READ_OBJ_BITS-1:0]   read_object,
  input  logic [glcm_pkg::GREY_BITS-1:0]       read_first,
  input  logic [glcm_pkg::GREY_BITS-1:0]       read_second,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [COUNT_BITS-1:0]                count,
  output logic [COUNT_BITS-1:0]                pair_total,
  input  logic                                 cfg_write,
  input  logic [glcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [glcm_pkg::SIZE_BITS-1:0]       cfg_data
);
  import glcm_pkg::*;

  logic init_done;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  glcm_front #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .GREY_LEVELS(GREY_LEVELS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .grey        (grey),
    .object      (object),
    .read_object (read_object),
    .read_first  (read_first),
    .read_second (read_second),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .init_done   (init_done),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  glcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  glcm_back #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .GREY_LEVELS(GREY_LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (pop_valid),
    .cmd_pop    (pop),
    .cmd        (pop_cmd),
    .init_done  (init_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .count      (count),
    .pair_total (pair_total)
  );

endmodule
